// ===== sv/rwwa_pkg.sv =====
// Shared constants and types for the ramp weighted window average unit.
package rwwa_pkg;

    localparam int unsigned SAMPLE_W    = 13;
    localparam int unsigned WINDOW_LEN  = 81;
    localparam int unsigned PTR_W       = 7;
    localparam int unsigned PLAIN_W     = 20;
    localparam int unsigned WSUM_W      = 27;
    localparam int unsigned ROUND_W     = WSUM_W + 1;
    localparam int unsigned Y_W         = ROUND_W - 3;
    localparam int unsigned RECIP_W     = 15;
    localparam int unsigned PROD_W      = Y_W + RECIP_W;
    localparam int unsigned RECIP_SHIFT = 25;
    localparam int unsigned Q_W         = PROD_W - RECIP_SHIFT;
    localparam int unsigned QM_W        = Y_W + 1;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [PTR_W-1:0]    t_ptr;
    typedef logic [PLAIN_W-1:0]  t_plain;
    typedef logic [WSUM_W-1:0]   t_wsum;

    localparam t_ptr    LAST_SLOT   = t_ptr'(WINDOW_LEN - 1);
    localparam t_ptr    FULL_COUNT  = t_ptr'(WINDOW_LEN);
    localparam t_wsum   WEIGHT_TOP  = t_wsum'(160);
    localparam t_wsum   WEIGHT_DROP = t_wsum'(79);
    localparam logic [ROUND_W-1:0] ROUND_HALF = ROUND_W'(4860);
    localparam logic [PROD_W-1:0]  RECIP_MUL  = PROD_W'(27616);
    localparam logic [QM_W-1:0]    DIV_ODD    = QM_W'(1215);
    localparam logic [Q_W:0]       SAMPLE_MAX = (Q_W + 1)'(8191);

endpackage

// ===== sv/rwwa_flux_if.sv =====
// Input channel carrying one flux sample per transaction.
interface rwwa_flux_if;
    logic               valid;
    logic               ready;
    rwwa_pkg::t_sample  flux_sample;

    modport source (output valid, output flux_sample, input ready);
    modport sink   (input valid, input flux_sample, output ready);
endinterface

// ===== sv/rwwa_avg_if.sv =====
// Output channel carrying one weighted average result per transaction.
interface rwwa_avg_if;
    logic               valid;
    logic               ready;
    rwwa_pkg::t_sample  weighted_average;
    logic               average_valid;

    modport source (output valid, output weighted_average, output average_valid, input ready);
    modport sink   (input valid, input weighted_average, input average_valid, output ready);
endinterface

// ===== sv/rwwa_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module rwwa_ram #(
    parameter int unsigned WIDTH = 13,
    parameter int unsigned DEPTH = 81
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ramp_weighted_window_average_unit.sv =====
// Ramp weighted 81 sample moving average of a flux sample stream.
//
// Usage: i_flux delivers one 13 bit flux sample per transaction; o_avg
// returns exactly one result per sample: the weighted mean of the last 81
// samples (weights 80 for the oldest up to 160 for the newest, divided by
// 9720, rounded to nearest, ties up) and the average_valid flag.
// For the first 80 samples after reset the result is 0 with average_valid low.
// A sample passes stages A, B, C, D and the output register to reach o_avg.
// Throughput: one sample per cycle unless o_avg stalls; the RAM is written
// once per sample, read as the pipeline moves; both sums update together.
// Reset (i_rst_n low at a clock edge) empties the pipeline, clears the sums,
// the fill count and the ring pointer; the window RAM is not swept, slots not
// yet written since reset are masked by the fill count.
// i_flux.ready stays low while i_rst_n is low.
// Stall: while o_avg is valid and not ready the whole pipeline holds and
// i_flux.ready drops in the same cycle; it rises again as soon as the
// pending result is taken.
module ramp_weighted_window_average_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rwwa_flux_if.sink   i_flux,
    rwwa_avg_if.source  o_avg
);

    logic                      w_en;
    logic                      w_accept;
    rwwa_pkg::t_sample         w_ram_rd;
    rwwa_pkg::t_sample         w_oldest;

    rwwa_pkg::t_ptr            r_ptr, n_ptr;
    rwwa_pkg::t_ptr            r_seen, n_seen;

    logic                      r_a_vld;
    logic                      r_a_fill;
    logic                      r_a_full;
    rwwa_pkg::t_sample         r_a_fresh;

    logic                      r_b_vld;
    logic                      r_b_full;
    rwwa_pkg::t_plain          r_psum, n_psum;
    rwwa_pkg::t_wsum           r_wsum, n_wsum;

    logic                      r_c_vld;
    logic                      r_c_full;
    logic [rwwa_pkg::Y_W-1:0]    r_c_y, n_c_y;
    logic [rwwa_pkg::PROD_W-1:0] r_c_prod, n_c_prod;
    logic [rwwa_pkg::ROUND_W-1:0] w_round;

    logic                      r_d_vld;
    logic                      r_d_full;
    logic [rwwa_pkg::Y_W-1:0]    r_d_y;
    logic [rwwa_pkg::Q_W-1:0]    r_d_q0, n_d_q0;
    logic [rwwa_pkg::QM_W-1:0]   r_d_qm, n_d_qm;

    logic [rwwa_pkg::QM_W-1:0]   w_rem;
    logic [rwwa_pkg::Q_W:0]      w_quot;
    rwwa_pkg::t_sample         n_out_avg;

    logic                      r_out_valid;
    logic                      r_out_full;
    rwwa_pkg::t_sample         r_out_avg;

    assign w_en           = !r_out_valid || o_avg.ready;
    assign i_flux.ready   = w_en && i_rst_n;
    assign w_accept       = i_flux.valid && i_flux.ready;

    rwwa_ram #(
        .WIDTH (rwwa_pkg::SAMPLE_W),
        .DEPTH (rwwa_pkg::WINDOW_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_ptr),
        .i_wdata (i_flux.flux_sample),
        .i_re    (w_en),
        .i_raddr (r_ptr),
        .o_rdata (w_ram_rd)
    );

    always_comb begin
        n_ptr  = (r_ptr == rwwa_pkg::LAST_SLOT) ? '0 : r_ptr + 1'b1;
        n_seen = (r_seen == rwwa_pkg::FULL_COUNT) ? r_seen : r_seen + 1'b1;
    end

    always_comb begin
        w_oldest = r_a_fill ? w_ram_rd : '0;
        n_psum   = r_psum - rwwa_pkg::PLAIN_W'(w_oldest) + rwwa_pkg::PLAIN_W'(r_a_fresh);
        n_wsum   = r_wsum - rwwa_pkg::WSUM_W'(r_psum)
                 - rwwa_pkg::WSUM_W'(w_oldest) * rwwa_pkg::WEIGHT_DROP
                 + rwwa_pkg::WSUM_W'(r_a_fresh) * rwwa_pkg::WEIGHT_TOP;
    end

    always_comb begin
        w_round  = rwwa_pkg::ROUND_W'(r_wsum) + rwwa_pkg::ROUND_HALF;
        n_c_y    = w_round[rwwa_pkg::ROUND_W-1:3];
        n_c_prod = rwwa_pkg::PROD_W'(n_c_y) * rwwa_pkg::RECIP_MUL;
    end

    always_comb begin
        n_d_q0 = r_c_prod[rwwa_pkg::PROD_W-1:rwwa_pkg::RECIP_SHIFT];
        n_d_qm = rwwa_pkg::QM_W'(n_d_q0) * rwwa_pkg::DIV_ODD;
    end

    always_comb begin
        w_rem  = rwwa_pkg::QM_W'(r_d_y) - r_d_qm;
        w_quot = (w_rem >= rwwa_pkg::DIV_ODD) ? {1'b0, r_d_q0} + 1'b1 : {1'b0, r_d_q0};
        if (!r_d_full) begin
            n_out_avg = '0;
        end else if (w_quot > rwwa_pkg::SAMPLE_MAX) begin
            n_out_avg = rwwa_pkg::SAMPLE_MAX[rwwa_pkg::SAMPLE_W-1:0];
        end else begin
            n_out_avg = w_quot[rwwa_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_seen      <= '0;
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_c_vld     <= 1'b0;
            r_d_vld     <= 1'b0;
            r_out_valid <= 1'b0;
            r_psum      <= '0;
            r_wsum      <= '0;
        end else if (w_en) begin
            if (w_accept) begin
                r_ptr  <= n_ptr;
                r_seen <= n_seen;
            end
            if (r_a_vld) begin
                r_psum <= n_psum;
                r_wsum <= n_wsum;
            end
            r_a_vld     <= w_accept;
            r_b_vld     <= r_a_vld;
            r_c_vld     <= r_b_vld;
            r_d_vld     <= r_c_vld;
            r_out_valid <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_fresh  <= i_flux.flux_sample;
            r_a_fill   <= (r_seen == rwwa_pkg::FULL_COUNT);
            r_a_full   <= (n_seen == rwwa_pkg::FULL_COUNT);
            r_b_full   <= r_a_full;
            r_c_full   <= r_b_full;
            r_c_y      <= n_c_y;
            r_c_prod   <= n_c_prod;
            r_d_full   <= r_c_full;
            r_d_y      <= r_c_y;
            r_d_q0     <= n_d_q0;
            r_d_qm     <= n_d_qm;
            r_out_full <= r_d_full;
            r_out_avg  <= n_out_avg;
        end
    end

    assign o_avg.valid            = r_out_valid;
    assign o_avg.weighted_average = r_out_avg;
    assign o_avg.average_valid    = r_out_full;

endmodule

// ===== sv/rwwa_checker.sv =====
// Port level checker for the ramp weighted window average unit, with its bind.
module rwwa_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_ready,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  rwwa_pkg::t_sample i_out_avg,
    input  logic              i_out_flag
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with no result pending");

    a_warmup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_flag |-> i_out_avg == '0)
        else $error("nonzero average during warm-up");

    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_flag |=> !(i_out_valid && !i_out_flag))
        else $error("average_valid fell without reset");

endmodule

bind ramp_weighted_window_average_unit rwwa_checker u_rwwa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_flux.ready),
    .i_out_valid (o_avg.valid),
    .i_out_ready (o_avg.ready),
    .i_out_avg   (o_avg.weighted_average),
    .i_out_flag  (o_avg.average_valid)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the ramp weighted window average unit: random traffic, self-checking.
module tb_top;

    localparam int unsigned RAMP_TOP    = 160;
    localparam int unsigned RAMP_DROP   = 79;
    localparam int unsigned RAMP_TOTAL  = 9720;
    localparam int unsigned FLUX_TOP    = 8191;
    localparam int unsigned ITEM_TARGET = 1050;
    localparam int unsigned QUIET_TAIL  = 120;
    localparam int unsigned DRAIN_LIMIT = 2000;
    localparam int unsigned SETTLE      = 20;

    typedef struct packed {
        rwwa_pkg::t_sample avg;
        logic              full;
    } t_mean;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rwwa_flux_if flux_ch ();
    rwwa_avg_if  avg_ch ();

    ramp_weighted_window_average_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_flux  (flux_ch),
        .o_avg   (avg_ch)
    );

    rwwa_pkg::t_sample pending_flux[$];
    t_mean             expected_means[$];

    rwwa_pkg::t_sample window_ring [rwwa_pkg::WINDOW_LEN] = '{default: '0};
    rwwa_pkg::t_ptr    oldest_slot = '0;
    rwwa_pkg::t_plain  plain_total = '0;
    rwwa_pkg::t_wsum   ramp_total  = '0;
    rwwa_pkg::t_ptr    fill_count  = '0;

    int unsigned total_items     = 0;
    int unsigned items_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned full_results    = 0;
    int unsigned error_count     = 0;
    logic        flux_taken      = 1'b0;
    int unsigned send_gap        = 0;
    int unsigned stall_left      = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_mean push_sample(rwwa_pkg::t_sample fresh);
        logic [63:0]       next_ramp;
        logic [63:0]       quot;
        rwwa_pkg::t_sample leaving;
        t_mean             r;
        leaving   = window_ring[oldest_slot];
        next_ramp = 64'(ramp_total) - 64'(plain_total) - 64'(RAMP_DROP) * 64'(leaving)
                  + 64'(RAMP_TOP) * 64'(fresh);
        ramp_total  = rwwa_pkg::t_wsum'(next_ramp);
        plain_total = rwwa_pkg::t_plain'(64'(plain_total) - 64'(leaving) + 64'(fresh));
        window_ring[oldest_slot] = fresh;
        oldest_slot = (oldest_slot == rwwa_pkg::LAST_SLOT) ? '0 : oldest_slot + 1'b1;
        if (fill_count < rwwa_pkg::FULL_COUNT) begin
            fill_count = fill_count + 1'b1;
        end
        r.avg  = '0;
        r.full = 1'b0;
        if (fill_count == rwwa_pkg::FULL_COUNT) begin
            quot   = (64'(ramp_total) + 64'(RAMP_TOTAL / 2)) / 64'(RAMP_TOTAL);
            r.avg  = (quot > 64'(FLUX_TOP)) ? '1 : rwwa_pkg::t_sample'(quot);
            r.full = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    task automatic queue_flux(rwwa_pkg::t_sample value);
        pending_flux = {pending_flux, value};
    endtask

    task automatic add_run(int unsigned value, int unsigned count);
        repeat (count) queue_flux(rwwa_pkg::t_sample'(value));
    endtask

    // Accept side: predict on every input transaction.
    always @(posedge clk) begin
        if (rst_n && flux_ch.valid && flux_ch.ready) begin
            expected_means = {expected_means, push_sample(flux_ch.flux_sample)};
            items_accepted <= items_accepted + 1;
            flux_taken     <= 1'b1;
        end else begin
            flux_taken <= 1'b0;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            flux_ch.valid       <= 1'b0;
            flux_ch.flux_sample <= '0;
        end else if (!flux_ch.valid || flux_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                flux_ch.valid <= 1'b0;
            end else if (pending_flux.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 4);
                flux_ch.valid <= 1'b0;
            end else if (pending_flux.size() > 0) begin
                flux_ch.flux_sample <= pending_flux.pop_front();
                flux_ch.valid       <= 1'b1;
            end else begin
                flux_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            avg_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            avg_ch.ready <= 1'b0;
        end else if (pending_flux.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            avg_ch.ready <= 1'b0;
        end else begin
            avg_ch.ready <= 1'b1;
        end
    end

    // Result side: compare each output transaction with the oldest prediction.
    always @(posedge clk) begin
        t_mean want;
        if (rst_n && avg_ch.valid && avg_ch.ready) begin
            if (expected_means.size() == 0) begin
                report_mismatch($sformatf("result avg=%0d valid=%0b with no sample pending",
                                          avg_ch.weighted_average, avg_ch.average_valid));
            end else begin
                want = expected_means.pop_front();
                if (avg_ch.weighted_average !== want.avg) begin
                    report_mismatch($sformatf("result %0d: weighted_average %0d, want %0d",
                                              results_checked, avg_ch.weighted_average,
                                              want.avg));
                end
                if (avg_ch.average_valid !== want.full) begin
                    report_mismatch($sformatf("result %0d: average_valid %0b, want %0b",
                                              results_checked, avg_ch.average_valid,
                                              want.full));
                end
                if (want.full) begin
                    full_results++;
                end
            end
            results_checked++;
        end
    end

    initial begin
        int unsigned kind;
        int unsigned len;
        int          walk;

        // Directed: field extremes and bit patterns during warm-up.
        queue_flux(13'd0);
        queue_flux(13'd8191);
        queue_flux(13'd0);
        queue_flux(13'd8191);
        queue_flux(13'd1);
        queue_flux(13'd8190);
        queue_flux(13'd4096);
        queue_flux(13'd4095);
        queue_flux(13'h1555);
        queue_flux(13'h0AAA);
        queue_flux(13'd2);
        queue_flux(13'd8189);
        // Full window of the largest sample, then a window that rounds exactly half up.
        add_run(FLUX_TOP, rwwa_pkg::WINDOW_LEN);
        add_run(0, 1);
        add_run(60, 1);
        add_run(0, rwwa_pkg::WINDOW_LEN - 2);

        while (pending_flux.size() < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind <= 4) begin
                repeat ($urandom_range(1, 40)) queue_flux(rwwa_pkg::t_sample'($urandom));
            end else if (kind <= 6) begin
                walk = $urandom_range(0, FLUX_TOP);
                len  = $urandom_range(20, 90);
                repeat (len) begin
                    walk = walk + $urandom_range(0, 128) - 64;
                    if (walk < 0) walk = 0;
                    if (walk > FLUX_TOP) walk = FLUX_TOP;
                    queue_flux(rwwa_pkg::t_sample'(walk));
                end
            end else if (kind == 7) begin
                add_run($urandom_range(0, FLUX_TOP),
                        $urandom_range(rwwa_pkg::WINDOW_LEN, rwwa_pkg::WINDOW_LEN + 20));
            end else if (kind == 8) begin
                add_run($urandom_range(0, 1) ? FLUX_TOP : 0, rwwa_pkg::WINDOW_LEN);
            end else begin
                add_run(0, 1);
                add_run(60, 1);
                add_run(0, rwwa_pkg::WINDOW_LEN - 2);
            end
        end
        total_items = pending_flux.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (items_accepted < total_items) @(posedge clk);
        len = 0;
        while (expected_means.size() != 0 && len < DRAIN_LIMIT) begin
            @(posedge clk);
            len++;
        end
        if (expected_means.size() != 0) begin
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      expected_means.size()));
        end
        repeat (SETTLE) @(posedge clk);

        $display("Fed %0d flux samples with random gaps and stalls; checked %0d results.",
                 total_items, results_checked);
        $display("%0d results had a full window, including max-value and half-way rounding cases.",
                 full_results);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout: run did not complete.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
